@@ rtl/core/h264ls_pkg.sv @@
// Package for the H.264 level selector: FSM states, limit table and level codes.
package h264ls_pkg;

  localparam int unsigned LevelRows = 17;
  localparam int unsigned Figures   = 6;
  localparam int unsigned RowW      = 5;
  localparam int unsigned ColW      = 3;
  localparam int unsigned LimitW    = 21;

  localparam int unsigned MbW       = 11;
  localparam int unsigned MbsW      = 21;
  localparam int unsigned NumW      = 20;
  localparam int unsigned ProdW     = 41;
  localparam int unsigned DpbW      = 26;
  localparam int unsigned QuotW     = 22;
  localparam int unsigned RateW     = 23;
  localparam int unsigned VbvW      = 22;
  localparam int unsigned FigW      = 26;
  localparam int unsigned CntW      = 5;

  localparam logic [7:0] ProfBaseline = 8'd66;
  localparam logic [7:0] ProfMain     = 8'd77;
  localparam logic [7:0] ProfHi444    = 8'd244;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MBS,
    ST_MUL,
    ST_DIVI,
    ST_DIV,
    ST_RND,
    ST_WALK,
    ST_OUT
  } state_e;

  // columns: field factor, MB/s, MB/frame, DPB MBs, VBV rate, VBV buffer
  localparam logic [LimitW-1:0] LvlLimit [LevelRows][Figures] = '{
    '{21'd1, 21'd1485,    21'd99,    21'd396,    21'd64,     21'd175},
    '{21'd1, 21'd1485,    21'd99,    21'd396,    21'd128,    21'd350},
    '{21'd1, 21'd3000,    21'd396,   21'd900,    21'd192,    21'd500},
    '{21'd1, 21'd6000,    21'd396,   21'd2376,   21'd384,    21'd1000},
    '{21'd1, 21'd11880,   21'd396,   21'd2376,   21'd768,    21'd2000},
    '{21'd1, 21'd11880,   21'd396,   21'd2376,   21'd2000,   21'd2000},
    '{21'd2, 21'd19800,   21'd792,   21'd4752,   21'd4000,   21'd4000},
    '{21'd2, 21'd20250,   21'd1620,  21'd8100,   21'd4000,   21'd4000},
    '{21'd2, 21'd40500,   21'd1620,  21'd8100,   21'd10000,  21'd10000},
    '{21'd2, 21'd108000,  21'd3600,  21'd18000,  21'd14000,  21'd14000},
    '{21'd2, 21'd216000,  21'd5120,  21'd20480,  21'd20000,  21'd20000},
    '{21'd2, 21'd245760,  21'd8192,  21'd32768,  21'd20000,  21'd25000},
    '{21'd2, 21'd245760,  21'd8192,  21'd32768,  21'd50000,  21'd62500},
    '{21'd2, 21'd522240,  21'd8704,  21'd34816,  21'd50000,  21'd62500},
    '{21'd1, 21'd589824,  21'd22080, 21'd110400, 21'd135000, 21'd135000},
    '{21'd1, 21'd983040,  21'd36864, 21'd184320, 21'd240000, 21'd240000},
    '{21'd1, 21'd2073600, 21'd36864, 21'd184320, 21'd240000, 21'd240000}
  };

  localparam logic [5:0] LvlCode [LevelRows] = '{
    6'd10, 6'd9, 6'd11, 6'd12, 6'd13, 6'd20, 6'd21, 6'd22, 6'd30,
    6'd31, 6'd32, 6'd40, 6'd41, 6'd42, 6'd50, 6'd51, 6'd52
  };

  function automatic logic [LimitW-1:0] lvl_limit(input logic [RowW-1:0] row,
                                                  input logic [ColW-1:0] col);
    logic [LimitW-1:0] lim;
    lim = '0;
    if ((row < RowW'(LevelRows)) && (col < ColW'(Figures))) begin
      lim = LvlLimit[row][col];
    end
    return lim;
  endfunction

  function automatic logic [5:0] lvl_code(input logic [RowW-1:0] row);
    logic [5:0] code;
    code = '0;
    if (row < RowW'(LevelRows)) begin
      code = LvlCode[row];
    end
    return code;
  endfunction

endpackage

@@ rtl/core/h264_level_selector_top.sv @@
// H.264 level selector: bit-serial figure computation and limit table walk.
// Steps from request acceptance to m_axis_tvalid: macroblock multiply, rate
//   multiply, rate divide when the quotient fits, then the limit table walk.
// Throughput: one request in flight; the next is accepted once the previous result
//   is registered, while that result may still wait.
// Reset: rst_ni asynchronous active low; returns to idle with no result pending.
module h264_level_selector_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_width[13:0], frame_height[27:14], ref_count[32:28], is_interlaced[33],
  // rate_numerator[53:34], rate_denominator[73:54], profile_code[81:74],
  // vbv_rate_kbps[101:82], vbv_size_kbit[121:102], zero[127:122]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // level_code[5:0], zero[7:6]
  output logic [7:0]   m_axis_tdata
);
  import h264ls_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             intl_q, intl_d;
  logic [19:0]      den_q, den_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [4:0]       refs_q, refs_d;
  logic [MbW-1:0]   mbh_q, mbh_d;
  logic [ProdW-1:0] mcand_q, mcand_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [MbsW-1:0]  mbs_q, mbs_d;
  logic [DpbW-1:0]  dpb_q, dpb_d;
  logic [19:0]      rem_q, rem_d;
  logic [RateW-1:0] rate_q, rate_d;
  logic [VbvW-1:0]  vr_q, vr_d;
  logic [VbvW-1:0]  vb_q, vb_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [5:0]       code_q, code_d;
  logic [5:0]       out_q, out_d;
  logic             ovld_q, ovld_d;

  logic [13:0] in_w, in_h;
  logic [7:0]  in_prof;
  logic [19:0] in_vr, in_vb;
  logic [MbW-1:0] mbw, mbh_in;
  logic [23:0] vr_mul, vb_mul;
  logic [MbsW-1:0] mbs_next;
  logic [20:0] trial;
  logic        qbit;
  logic        big;
  logic [FigW-1:0] fig;
  logic [FigW-1:0] lim;
  logic        in_rng;

  assign in_w    = s_axis_tdata[13:0];
  assign in_h    = s_axis_tdata[27:14];
  assign in_prof = s_axis_tdata[81:74];
  assign in_vr   = s_axis_tdata[101:82];
  assign in_vb   = s_axis_tdata[121:102];

  assign mbw = MbW'((15'(in_w) + 15'd15) >> 4);
  assign mbh_in = s_axis_tdata[33] ? {MbW'((15'(in_h) + 15'd31) >> 5)} << 1
                                   : MbW'((15'(in_h) + 15'd15) >> 4);

  // v*q with q in quarters, rounded half up after the divide by four
  always_comb begin
    if ((in_prof == ProfBaseline) || (in_prof == ProfMain)) begin
      vr_mul = {in_vr, 2'b00} + 24'd2;
      vb_mul = {in_vb, 2'b00} + 24'd2;
    end else if (in_prof == ProfHi444) begin
      vr_mul = {1'b0, in_vr, 3'b000} + {2'b00, in_vr, 2'b00} + 24'd2;
      vb_mul = {1'b0, in_vb, 3'b000} + {2'b00, in_vb, 2'b00} + 24'd2;
    end else begin
      vr_mul = {2'b00, in_vr, 2'b00} + 24'(in_vr) + 24'd2;
      vb_mul = {2'b00, in_vb, 2'b00} + 24'(in_vb) + 24'd2;
    end
  end

  assign mbs_next = mbs_q + (mbh_q[0] ? mcand_q[MbsW-1:0] : '0);
  assign big      = {1'b0, prod_q} >= {den_q, 22'b0};
  assign trial    = {rem_q, prod_q[QuotW-1]};
  assign qbit     = trial >= {1'b0, den_q};

  always_comb begin
    unique case (col_q)
      3'd0:    fig = FigW'(intl_q ? 2'd2 : 2'd1);
      3'd1:    fig = FigW'(rate_q);
      3'd2:    fig = FigW'(mbs_q);
      3'd3:    fig = dpb_q;
      3'd4:    fig = FigW'(vr_q);
      3'd5:    fig = FigW'(vb_q);
      default: fig = '0;
    endcase
  end

  assign lim    = FigW'(lvl_limit(row_q, col_q));
  assign in_rng = (row_q < RowW'(LevelRows)) && (col_q < ColW'(Figures));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, out_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    intl_d  = intl_q;
    den_d   = den_q;
    num_d   = num_q;
    refs_d  = refs_q;
    mbh_d   = mbh_q;
    mcand_d = mcand_q;
    prod_d  = prod_q;
    mbs_d   = mbs_q;
    dpb_d   = dpb_q;
    rem_d   = rem_q;
    rate_d  = rate_q;
    vr_d    = vr_q;
    vb_d    = vb_q;
    row_d   = row_q;
    col_d   = col_q;
    code_d  = code_q;
    out_d   = out_q;
    ovld_d  = ovld_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          intl_d  = s_axis_tdata[33];
          refs_d  = s_axis_tdata[32:28];
          num_d   = s_axis_tdata[53:34];
          den_d   = s_axis_tdata[73:54];
          vr_d    = vr_mul[23:2];
          vb_d    = vb_mul[23:2];
          mcand_d = ProdW'(mbw);
          mbh_d   = mbh_in;
          mbs_d   = '0;
          cnt_d   = '0;
          state_d = ST_MBS;
        end
      end
      ST_MBS: begin
        mbs_d   = mbs_next;
        mbh_d   = mbh_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(MbW - 1)) begin
          mcand_d = ProdW'(mbs_next);
          prod_d  = '0;
          dpb_d   = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = prod_q + (num_q[0] ? mcand_q : '0);
        dpb_d   = dpb_q + (refs_q[0] ? mcand_q[DpbW-1:0] : '0);
        num_d   = num_q >> 1;
        refs_d  = refs_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        // quotient of 2^22 or more exceeds every MB/s limit
        cnt_d  = '0;
        rate_d = '0;
        rem_d  = {1'b0, prod_q[ProdW-1:QuotW]};
        if (big) begin
          rate_d  = '1;
          row_d   = '0;
          col_d   = '0;
          state_d = ST_WALK;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d   = qbit ? 20'(trial - {1'b0, den_q}) : trial[19:0];
        rate_d  = {rate_q[RateW-2:0], qbit};
        prod_d  = prod_q << 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(QuotW - 1)) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        rate_d  = rate_q + RateW'(rem_q != '0);
        row_d   = '0;
        col_d   = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (in_rng) begin
          if (fig > lim) begin
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end else begin
          // interlace recheck against the chosen row
          code_d = '0;
          if ((row_q < RowW'(LevelRows)) && (col_q == ColW'(Figures)) &&
              (FigW'(intl_q ? 2'd2 : 2'd1) <= FigW'(lvl_limit(row_q, '0)))) begin
            code_d = lvl_code(row_q);
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovld_q || m_axis_tready) begin
          out_d   = code_q;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    intl_q  <= intl_d;
    den_q   <= den_d;
    num_q   <= num_d;
    refs_q  <= refs_d;
    mbh_q   <= mbh_d;
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
    mbs_q   <= mbs_d;
    dpb_q   <= dpb_d;
    rem_q   <= rem_d;
    rate_q  <= rate_d;
    vr_q    <= vr_d;
    vb_q    <= vb_d;
    row_q   <= row_d;
    col_q   <= col_d;
    code_q  <= code_d;
    out_q   <= out_d;
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MBS))
    else $error("accepted request did not start the macroblock multiply");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below denominator");

  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((row_q <= RowW'(LevelRows)) && (col_q <= ColW'(Figures))))
    else $error("table walk out of bounds");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[7:6] == 2'b00) && (m_axis_tdata[5:0] <= 6'd52)))
    else $error("level code out of range");

  a_result_loads_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready)) |=>
      (m_axis_tvalid && (state_q == ST_IDLE)))
    else $error("result not registered on a free output");

endmodule
